>>> sv/spi_master_with_fifos_assert.svh
// ---------------------------------------------------------------------------
// spi_master_with_fifos assertion macros
// Shared concurrent-check shorthands; expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef SPI_MASTER_WITH_FIFOS_ASSERT_SVH
`define SPI_MASTER_WITH_FIFOS_ASSERT_SVH

// same-cycle implication
`define SPIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/spim_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spim_pkg
// Shared types, constants and helpers for the SPI master with FIFOs.
// ---------------------------------------------------------------------------
package spim_pkg;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int WORD_W     = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  // register reset values
  localparam logic [4:0]  FRAME_BITS_RST = 5'd8;
  localparam logic [7:0]  CLOCK_RATE_RST = 8'd0;
  localparam logic [7:0]  PRESCALE_RST   = 8'd2;
  localparam logic [15:0] HALF_RST       = 16'd1;

  // item operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_TICK   = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_FRAME_BITS = 3'd0,
    REG_POLARITY   = 3'd1,
    REG_PHASE      = 3'd2,
    REG_CLOCK_RATE = 3'd3,
    REG_PRESCALE   = 3'd4,
    REG_ENABLE     = 3'd5
  } reg_idx_t;

  // live configuration as seen by the shift engine
  typedef struct packed {
    logic [4:0]        frame_len;  // clamped to 4..16
    logic              polarity;
    logic              phase;
    logic              enable;
    logic [WORD_W-1:0] half;       // ticks per half bit
  } cfg_t;

  // engine requests towards the FIFOs
  typedef struct packed {
    logic              tx_pop;
    logic              rx_push;
    logic [WORD_W-1:0] rx_word;
  } eng_req_t;

  // engine state after the current beat
  typedef struct packed {
    logic active;
    logic second;
    logic mosi;
  } eng_stat_t;

  // FIFO fill flags, now and after the current beat
  typedef struct packed {
    logic full;
    logic empty;
    logic full_next;
    logic empty_next;
  } fifo_stat_t;

  // one result beat
  typedef struct packed {
    logic [WORD_W-1:0] read_word;
    logic              read_valid;
    logic              write_dropped;
    logic              sck_level;
    logic              mosi_level;
    logic              select_n;
    logic              tx_not_full;
    logic              rx_not_empty;
    logic              busy_res;
  } res_t;

  // low n bits set
  function automatic logic [WORD_W-1:0] frame_mask(input logic [4:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (5'(i) < n);
    end
    return m;
  endfunction

endpackage

>>> sv/spim_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spim_regs
// APB register bank; keeps the half-bit tick count ready as a register.
// ---------------------------------------------------------------------------
module spim_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spim_pkg::ADDR_W-1:0] paddr,
  input  logic [spim_pkg::DATA_W-1:0] pwdata,
  output logic [spim_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output spim_pkg::cfg_t             cfg
);

  logic [4:0]  frame_bits;
  logic        polarity;
  logic        phase;
  logic [7:0]  clock_rate;
  logic [7:0]  prescale;
  logic        enable;
  logic [15:0] half;
  logic [15:0] half_next;

  spim_pkg::reg_idx_t idx;
  logic               wr;
  logic [7:0]         pre_src;
  logic [7:0]         rate_src;
  logic [6:0]         pre_half;
  logic [8:0]         rate_plus;

  assign pready = 1'b1;
  assign idx    = spim_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;

  // half period = max(prescale/2, 1) * (rate + 1), from the value being written
  always_comb begin
    pre_src   = prescale;
    rate_src  = clock_rate;
    if (wr && idx == spim_pkg::REG_PRESCALE) begin
      pre_src = pwdata[7:0];
    end
    if (wr && idx == spim_pkg::REG_CLOCK_RATE) begin
      rate_src = pwdata[7:0];
    end
    pre_half  = (pre_src[7:1] == 7'd0) ? 7'd1 : pre_src[7:1];
    rate_plus = {1'b0, rate_src} + 9'd1;
    half_next = {9'd0, pre_half} * {7'd0, rate_plus};
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits <= spim_pkg::FRAME_BITS_RST;
      polarity   <= 1'b0;
      phase      <= 1'b0;
      clock_rate <= spim_pkg::CLOCK_RATE_RST;
      prescale   <= spim_pkg::PRESCALE_RST;
      enable     <= 1'b0;
      half       <= spim_pkg::HALF_RST;
    end else if (wr) begin
      half <= half_next;
      case (idx)
        spim_pkg::REG_FRAME_BITS: frame_bits <= pwdata[4:0];
        spim_pkg::REG_POLARITY:   polarity   <= pwdata[0];
        spim_pkg::REG_PHASE:      phase      <= pwdata[0];
        spim_pkg::REG_CLOCK_RATE: clock_rate <= pwdata[7:0];
        spim_pkg::REG_PRESCALE:   prescale   <= pwdata[7:0];
        spim_pkg::REG_ENABLE:     enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (idx)
      spim_pkg::REG_FRAME_BITS: prdata = {27'd0, frame_bits};
      spim_pkg::REG_POLARITY:   prdata = {31'd0, polarity};
      spim_pkg::REG_PHASE:      prdata = {31'd0, phase};
      spim_pkg::REG_CLOCK_RATE: prdata = {24'd0, clock_rate};
      spim_pkg::REG_PRESCALE:   prdata = {24'd0, prescale};
      spim_pkg::REG_ENABLE:     prdata = {31'd0, enable};
      default:                  prdata = '0;
    endcase
  end

  // frame size clamped to 4..16
  always_comb begin
    if (frame_bits < 5'd4) begin
      cfg.frame_len = 5'd4;
    end else if (frame_bits > 5'd16) begin
      cfg.frame_len = 5'd16;
    end else begin
      cfg.frame_len = frame_bits;
    end
    cfg.polarity = polarity;
    cfg.phase    = phase;
    cfg.enable   = enable;
    cfg.half     = half;
  end

endmodule

>>> sv/spim_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spim_fifo
// Word FIFO with head/tail pointers and fill count; head word read directly.
// ---------------------------------------------------------------------------
module spim_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  input  logic [spim_pkg::WORD_W-1:0] wdata,
  output logic [spim_pkg::WORD_W-1:0] rdata,
  output spim_pkg::fifo_stat_t       stat
);

  logic [spim_pkg::WORD_W-1:0] mem [spim_pkg::FIFO_DEPTH];
  logic [spim_pkg::PTR_W-1:0]  head;
  logic [spim_pkg::PTR_W-1:0]  tail;
  logic [spim_pkg::CNT_W-1:0]  count;
  logic [spim_pkg::CNT_W-1:0]  count_next;
  logic                        push_ok;
  logic                        pop_ok;

  localparam logic [spim_pkg::PTR_W-1:0] LAST = spim_pkg::PTR_W'(spim_pkg::FIFO_DEPTH - 1);
  localparam logic [spim_pkg::CNT_W-1:0] FULL = spim_pkg::CNT_W'(spim_pkg::FIFO_DEPTH);

  assign stat.full  = (count == FULL);
  assign stat.empty = (count == '0);
  assign push_ok    = push & ~stat.full;
  assign pop_ok     = pop & ~stat.empty;

  // fill count after this beat
  always_comb begin
    count_next = count;
    if (push_ok && !pop_ok) begin
      count_next = count + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_next = count - 1'b1;
    end
  end

  assign stat.full_next  = (count_next == FULL);
  assign stat.empty_next = (count_next == '0);

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (pop_ok) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= wdata;
    end
  end

  assign rdata = mem[head];

endmodule

>>> sv/spim_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spim_engine
// Frame sequencer: divider, SCK phase, shift registers and bit count.
// ---------------------------------------------------------------------------
`include "spi_master_with_fifos_assert.svh"

module spim_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick,
  input  logic                       miso,
  input  spim_pkg::cfg_t             cfg,
  input  logic [spim_pkg::WORD_W-1:0] tx_word,
  input  logic                       tx_empty,
  input  logic                       rx_full,
  output spim_pkg::eng_req_t         req,
  output spim_pkg::eng_stat_t        stat
);

  logic        active;
  logic        second;
  logic        mosi;
  logic [15:0] shift_out;
  logic [15:0] shift_in;
  logic [4:0]  bit_cnt;
  logic [15:0] div_cnt;

  logic        active_next;
  logic        second_next;
  logic        mosi_next;
  logic [15:0] shift_out_next;
  logic [15:0] shift_in_next;
  logic [4:0]  bit_cnt_next;
  logic [15:0] div_cnt_next;

  logic [15:0] mask;
  logic [3:0]  msb;
  logic [15:0] loaded;
  logic [15:0] div_inc;
  logic [4:0]  bit_inc;
  logic [15:0] sampled;

  assign mask    = spim_pkg::frame_mask(cfg.frame_len);
  assign msb     = 4'(cfg.frame_len - 5'd1);
  assign loaded  = tx_word & mask;
  assign div_inc = div_cnt + 16'd1;
  assign bit_inc = bit_cnt + 5'd1;
  assign sampled = {shift_in[14:0], miso};

  // next state for one tick
  always_comb begin
    active_next    = active;
    second_next    = second;
    mosi_next      = mosi;
    shift_out_next = shift_out;
    shift_in_next  = shift_in;
    bit_cnt_next   = bit_cnt;
    div_cnt_next   = div_cnt;
    req            = '0;
    if (tick) begin
      if (!cfg.enable) begin
        // abort or stay idle
        active_next  = 1'b0;
        second_next  = 1'b0;
        div_cnt_next = '0;
        bit_cnt_next = '0;
        mosi_next    = 1'b0;
      end else if (!active) begin
        // start a frame when a word is queued
        if (!tx_empty) begin
          req.tx_pop     = 1'b1;
          shift_in_next  = '0;
          bit_cnt_next   = '0;
          div_cnt_next   = '0;
          active_next    = 1'b1;
          second_next    = 1'b0;
          shift_out_next = loaded;
          if (!cfg.phase) begin
            mosi_next      = loaded[msb];
            shift_out_next = {loaded[14:0], 1'b0};
          end
        end
      end else if (div_inc < cfg.half) begin
        div_cnt_next = div_inc;
      end else begin
        div_cnt_next = '0;
        if (!second) begin
          // first edge of the bit
          second_next = 1'b1;
          if (!cfg.phase) begin
            shift_in_next = sampled;
          end else begin
            mosi_next      = shift_out[msb];
            shift_out_next = {shift_out[14:0], 1'b0};
          end
        end else begin
          // closing edge of the bit
          second_next = 1'b0;
          if (cfg.phase) begin
            shift_in_next = sampled;
          end
          if (bit_inc >= cfg.frame_len) begin
            req.rx_push  = ~rx_full;
            req.rx_word  = (cfg.phase ? sampled : shift_in) & mask;
            active_next  = 1'b0;
            bit_cnt_next = '0;
            mosi_next    = 1'b0;
          end else begin
            bit_cnt_next = bit_inc;
            if (!cfg.phase) begin
              mosi_next      = shift_out[msb];
              shift_out_next = {shift_out[14:0], 1'b0};
            end
          end
        end
      end
    end
  end

  assign stat.active = active_next;
  assign stat.second = second_next;
  assign stat.mosi   = mosi_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      second    <= 1'b0;
      mosi      <= 1'b0;
      shift_out <= '0;
      shift_in  <= '0;
      bit_cnt   <= '0;
      div_cnt   <= '0;
    end else begin
      active    <= active_next;
      second    <= second_next;
      mosi      <= mosi_next;
      shift_out <= shift_out_next;
      shift_in  <= shift_in_next;
      bit_cnt   <= bit_cnt_next;
      div_cnt   <= div_cnt_next;
    end
  end

  // idle means divider, phase and bit count all parked
  `SPIM_ASSERT_NOW(a_idle_parked, !active, div_cnt == '0 && !second && bit_cnt == '0, "idle state not parked")
  `SPIM_ASSERT_NOW(a_idle_mosi, !active, !mosi, "MOSI latch set while idle")
  `SPIM_ASSERT_NEXT(a_disable_stops, tick && !cfg.enable, !active, "frame survived a disabled tick")

endmodule

>>> sv/spi_master_with_fifos.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spi_master_with_fifos
// SPI master with 8-word transmit and receive FIFOs, modes 0 to 3.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per item: op selects
//   a data write (push write_word to the transmit FIFO), a data read (pop the
//   receive FIFO) or a peripheral clock tick carrying miso_bit.
//   Output channel (out_valid/out_stall) returns exactly one result beat per
//   item: read data and flags plus SCK, MOSI, select and FIFO status as they
//   stand after the item.
//   One item is taken per cycle while in_stall is low. The item is folded
//   into the state in its accept cycle and the result lands in an output
//   register backed by a one-beat skid register, so in_stall only rises
//   once a result waits in the skid stage.
//   Configuration goes through the APB port (pready always high); write it
//   only while no beat is in flight and the engine is idle.
//   Reset (rst, synchronous) empties both FIFOs, parks the engine with SCK
//   at the polarity and select high, and drops any held result beats.
// ---------------------------------------------------------------------------
`include "spi_master_with_fifos_assert.svh"

module spi_master_with_fifos (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [15:0]                write_word,
  input  logic                       miso_bit,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                read_word,
  output logic                       read_valid,
  output logic                       write_dropped,
  output logic                       sck_level,
  output logic                       mosi_level,
  output logic                       select_n,
  output logic                       tx_not_full,
  output logic                       rx_not_empty,
  output logic                       busy_res,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spim_pkg::ADDR_W-1:0] paddr,
  input  logic [spim_pkg::DATA_W-1:0] pwdata,
  output logic [spim_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  spim_pkg::cfg_t       cfg;
  spim_pkg::eng_req_t   req;
  spim_pkg::eng_stat_t  eng_stat;
  spim_pkg::fifo_stat_t tx_stat;
  spim_pkg::fifo_stat_t rx_stat;
  spim_pkg::op_t        op_in;
  spim_pkg::res_t       res_now;
  spim_pkg::res_t       out_res;
  spim_pkg::res_t       skid_res;

  logic        skid_valid;
  logic        accept;
  logic        is_write;
  logic        is_read;
  logic        is_tick;
  logic        tx_push;
  logic        rx_pop;
  logic [15:0] tx_head;
  logic [15:0] rx_head;

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign op_in    = spim_pkg::op_t'(op);

  // op decode
  always_comb begin
    is_write = 1'b0;
    is_read  = 1'b0;
    is_tick  = 1'b0;
    case (op_in)
      spim_pkg::OP_WRITE:  is_write = accept;
      spim_pkg::OP_READ:   is_read  = accept;
      spim_pkg::OP_TICK:   is_tick  = accept;
      spim_pkg::OP_STATUS: ;
      default: ;
    endcase
  end

  assign tx_push = is_write & ~tx_stat.full;
  assign rx_pop  = is_read & ~rx_stat.empty;

  spim_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spim_fifo u_tx_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (tx_push),
    .pop   (req.tx_pop),
    .wdata (write_word),
    .rdata (tx_head),
    .stat  (tx_stat)
  );

  spim_fifo u_rx_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (req.rx_push),
    .pop   (rx_pop),
    .wdata (req.rx_word),
    .rdata (rx_head),
    .stat  (rx_stat)
  );

  spim_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .tick     (is_tick),
    .miso     (miso_bit),
    .cfg      (cfg),
    .tx_word  (tx_head),
    .tx_empty (tx_stat.empty),
    .rx_full  (rx_stat.full),
    .req      (req),
    .stat     (eng_stat)
  );

  // result for the beat being accepted
  always_comb begin
    res_now.read_word     = rx_pop ? rx_head : '0;
    res_now.read_valid    = rx_pop;
    res_now.write_dropped = is_write & tx_stat.full;
    res_now.sck_level     = eng_stat.active ? (cfg.polarity ^ eng_stat.second) : cfg.polarity;
    res_now.mosi_level    = eng_stat.active & eng_stat.mosi;
    res_now.select_n      = ~eng_stat.active;
    res_now.tx_not_full   = ~tx_stat.full_next;
    res_now.rx_not_empty  = ~rx_stat.empty_next;
    res_now.busy_res      = eng_stat.active | ~tx_stat.empty_next;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_now;
      end
    end else if (accept) begin
      skid_res <= res_now;
    end
  end

  assign read_word     = out_res.read_word;
  assign read_valid    = out_res.read_valid;
  assign write_dropped = out_res.write_dropped;
  assign sck_level     = out_res.sck_level;
  assign mosi_level    = out_res.mosi_level;
  assign select_n      = out_res.select_n;
  assign tx_not_full   = out_res.tx_not_full;
  assign rx_not_empty  = out_res.rx_not_empty;
  assign busy_res      = out_res.busy_res;

  // skid beat only exists behind a held output beat
  `SPIM_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid beat without output beat")
  `SPIM_ASSERT_NEXT(a_stall_to_skid, accept && out_valid && out_stall, skid_valid, "beat lost on stall")
  `SPIM_ASSERT_NEXT(a_drain_empty, out_valid && !out_stall && !skid_valid && !accept, !out_valid, "beat repeated after drain")

endmodule

>>> verif/tb_spi_master_with_fifos.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_spi_master_with_fifos
// Self-checking bench for the SPI master with transmit and receive FIFOs.
// Beats of data writes, data reads, clock ticks and status polls are driven
// with random gaps, while the result side stalls at random. A scoreboard
// keeps its own copy of the FIFOs, shift engine and registers, predicts the
// result of every accepted beat and checks the results in order. Register
// settings change between phases over the APB port, extremes included.
// ---------------------------------------------------------------------------
module tb_spi_master_with_fifos;

  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 100;

  // -------------------------------------------------------------------------
  // scoreboard: mirror of the master, queue of expected result beats
  // -------------------------------------------------------------------------
  class spi_result_tracker;
    logic [4:0]     frame_reg;
    logic           pol_reg, pha_reg, en_reg;
    logic [7:0]     rate_reg, presc_reg;
    logic [15:0]    tx_mem [spim_pkg::FIFO_DEPTH];
    logic [15:0]    rx_mem [spim_pkg::FIFO_DEPTH];
    int             tx_head, tx_fill, rx_head, rx_fill;
    logic [15:0]    out_shift, in_shift;
    int             div_cnt, bits_done;
    logic           active, second, mosi;
    spim_pkg::res_t expected_q[$];
    int             errors, beat_no;

    function new();
      frame_reg = spim_pkg::FRAME_BITS_RST;
      pol_reg   = 1'b0;
      pha_reg   = 1'b0;
      en_reg    = 1'b0;
      rate_reg  = spim_pkg::CLOCK_RATE_RST;
      presc_reg = spim_pkg::PRESCALE_RST;
      tx_head   = 0;
      tx_fill   = 0;
      rx_head   = 0;
      rx_fill   = 0;
      out_shift = '0;
      in_shift  = '0;
      errors    = 0;
      beat_no   = 0;
      go_idle();
    endfunction

    function void set_reg(spim_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        spim_pkg::REG_FRAME_BITS: frame_reg = v[4:0];
        spim_pkg::REG_POLARITY:   pol_reg   = v[0];
        spim_pkg::REG_PHASE:      pha_reg   = v[0];
        spim_pkg::REG_CLOCK_RATE: rate_reg  = v[7:0];
        spim_pkg::REG_PRESCALE:   presc_reg = v[7:0];
        spim_pkg::REG_ENABLE:     en_reg    = v[0];
        default: ;
      endcase
    endfunction

    // frame size clamped to 4..16
    function int frame_len();
      if (frame_reg < 5'd4) return 4;
      if (frame_reg > 5'd16) return 16;
      return int'(frame_reg);
    endfunction

    // ticks per half bit; odd prescale rounds down, prescale minimum of 2
    function int half_ticks();
      int p;
      p = int'(presc_reg & 8'hFE);
      if (p < 2) p = 2;
      return (p / 2) * (int'(rate_reg) + 1);
    endfunction

    function logic [15:0] low_bits(int n);
      return 16'((17'd1 << n) - 17'd1);
    endfunction

    function void go_idle();
      active    = 1'b0;
      second    = 1'b0;
      div_cnt   = 0;
      bits_done = 0;
      mosi      = 1'b0;
    endfunction

    function void drive_next(int n);
      mosi      = out_shift[n-1];
      out_shift = out_shift << 1;
    endfunction

    function void clock_tick(logic m);
      int n;
      n = frame_len();
      // disable aborts any frame, FIFOs kept
      if (!en_reg) begin
        go_idle();
        return;
      end
      // idle: start a frame when a word waits
      if (!active) begin
        if (tx_fill > 0) begin
          out_shift = tx_mem[tx_head] & low_bits(n);
          tx_head   = (tx_head + 1) % spim_pkg::FIFO_DEPTH;
          tx_fill--;
          in_shift  = '0;
          bits_done = 0;
          div_cnt   = 0;
          active    = 1'b1;
          second    = 1'b0;
          if (!pha_reg) drive_next(n);
        end
        return;
      end
      div_cnt++;
      if (div_cnt < half_ticks()) return;
      div_cnt = 0;
      // first edge of the bit
      if (!second) begin
        second = 1'b1;
        if (!pha_reg) in_shift = {in_shift[14:0], m};
        else drive_next(n);
        return;
      end
      // second edge: sample or drive, then count the bit
      second = 1'b0;
      if (pha_reg) in_shift = {in_shift[14:0], m};
      bits_done++;
      if (bits_done >= n) begin
        // overrun drops the word
        if (rx_fill < spim_pkg::FIFO_DEPTH) begin
          rx_mem[(rx_head + rx_fill) % spim_pkg::FIFO_DEPTH] = in_shift & low_bits(n);
          rx_fill++;
        end
        go_idle();
      end else if (!pha_reg) begin
        drive_next(n);
      end
    endfunction

    // accepted input beat: update the mirror, queue the expected result
    function void note_item(spim_pkg::op_t o, logic [15:0] w, logic m);
      spim_pkg::res_t r;
      r = '0;
      case (o)
        spim_pkg::OP_WRITE: begin
          if (tx_fill < spim_pkg::FIFO_DEPTH) begin
            tx_mem[(tx_head + tx_fill) % spim_pkg::FIFO_DEPTH] = w;
            tx_fill++;
          end else begin
            r.write_dropped = 1'b1;
          end
        end
        spim_pkg::OP_READ: begin
          if (rx_fill > 0) begin
            r.read_word  = rx_mem[rx_head];
            r.read_valid = 1'b1;
            rx_head      = (rx_head + 1) % spim_pkg::FIFO_DEPTH;
            rx_fill--;
          end
        end
        spim_pkg::OP_TICK: clock_tick(m);
        default: ;
      endcase
      r.sck_level    = active ? (pol_reg ^ second) : pol_reg;
      r.mosi_level   = active ? mosi : 1'b0;
      r.select_n     = !active;
      r.tx_not_full  = (tx_fill < spim_pkg::FIFO_DEPTH);
      r.rx_not_empty = (rx_fill > 0);
      r.busy_res     = active || (tx_fill > 0);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("%0t ns: beat %0d: %s", $time, beat_no, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // accepted result beat against the oldest expectation
    task check_result(spim_pkg::res_t got);
      spim_pkg::res_t want;
      beat_no++;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("read_word", got.read_word, want.read_word);
      compare_field("read_valid", got.read_valid, want.read_valid);
      compare_field("write_dropped", got.write_dropped, want.write_dropped);
      compare_field("sck_level", got.sck_level, want.sck_level);
      compare_field("mosi_level", got.mosi_level, want.mosi_level);
      compare_field("select_n", got.select_n, want.select_n);
      compare_field("tx_not_full", got.tx_not_full, want.tx_not_full);
      compare_field("rx_not_empty", got.rx_not_empty, want.rx_not_empty);
      compare_field("busy_res", got.busy_res, want.busy_res);
    endtask
  endclass

  // -------------------------------------------------------------------------
  // signals and DUT
  // -------------------------------------------------------------------------
  logic                        clk;
  logic                        rst;
  logic                        in_valid, in_stall;
  logic [1:0]                  op;
  logic [15:0]                 write_word;
  logic                        miso_bit;
  logic                        out_valid, out_stall;
  logic [15:0]                 read_word;
  logic                        read_valid, write_dropped, sck_level, mosi_level, select_n;
  logic                        tx_not_full, rx_not_empty, busy_res;
  logic                        psel, penable, pwrite, pready;
  logic [spim_pkg::ADDR_W-1:0] paddr;
  logic [spim_pkg::DATA_W-1:0] pwdata, prdata;

  spi_result_tracker tracker = new();
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  spi_master_with_fifos dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .write_word(write_word), .miso_bit(miso_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_word(read_word), .read_valid(read_valid), .write_dropped(write_dropped),
    .sck_level(sck_level), .mosi_level(mosi_level), .select_n(select_n),
    .tx_not_full(tx_not_full), .rx_not_empty(rx_not_empty), .busy_res(busy_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // -------------------------------------------------------------------------
  // result side: random stall per beat, check each accepted beat
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      tracker.check_result({read_word, read_valid, write_dropped, sck_level, mosi_level,
                            select_n, tx_not_full, rx_not_empty, busy_res});
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      n = rx_calm ? 0 : $urandom_range(0, 9);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // watchdog: too long with no beat and no register access
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[spi_master_with_fifos] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // drivers
  // -------------------------------------------------------------------------
  task send_item(spim_pkg::op_t o, logic [15:0] w, logic m);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    write_word <= w;
    miso_bit   <= m;
    do @(posedge clk); while (in_stall);
    tracker.note_item(o, w, m);
  endtask

  task tick_run(int count);
    repeat (count) send_item(spim_pkg::OP_TICK, 16'($urandom), 1'($urandom));
  endtask

  // stop sending and wait for every outstanding result
  task settle_results();
    in_valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
  endtask

  task apb_write(spim_pkg::reg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, v);
  endtask

  // disable (aborting any frame), then load a full setting
  task reconfigure(int frame, bit pol, bit pha, int rate, int presc, bit en);
    settle_results();
    apb_write(spim_pkg::REG_ENABLE, 32'd0);
    send_item(spim_pkg::OP_TICK, 16'($urandom), 1'($urandom));
    settle_results();
    apb_write(spim_pkg::REG_FRAME_BITS, 32'(frame));
    apb_write(spim_pkg::REG_POLARITY, 32'(pol));
    apb_write(spim_pkg::REG_PHASE, 32'(pha));
    apb_write(spim_pkg::REG_CLOCK_RATE, 32'(rate));
    apb_write(spim_pkg::REG_PRESCALE, 32'(presc));
    apb_write(spim_pkg::REG_ENABLE, 32'(en));
  endtask

  // one random phase of mixed beats
  task random_phase(int count);
    int read_pct, write_pct, r;
    read_pct  = $urandom_range(3, 25);
    write_pct = $urandom_range(8, 25);
    tx_calm   = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
      r = $urandom_range(0, 99);
      if (r < write_pct)
        send_item(spim_pkg::OP_WRITE, 16'($urandom), 1'($urandom));
      else if (r < write_pct + read_pct)
        send_item(spim_pkg::OP_READ, 16'($urandom), 1'($urandom));
      else if (r < write_pct + read_pct + 3)
        send_item(spim_pkg::OP_STATUS, 16'($urandom), 1'($urandom));
      else
        send_item(spim_pkg::OP_TICK, 16'($urandom), 1'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    int frame, presc, rate;
    rst        = 1'b1;
    in_valid   = 1'b0;
    op         = spim_pkg::OP_STATUS;
    write_word = '0;
    miso_bit   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset setting, disabled: tick, empty read, status poll
    send_item(spim_pkg::OP_TICK, 16'hFFFF, 1'b1);
    send_item(spim_pkg::OP_READ, 16'h0000, 1'b0);
    send_item(spim_pkg::OP_STATUS, 16'hFFFF, 1'b1);
    // fill the transmit FIFO, the ninth write is dropped
    send_item(spim_pkg::OP_WRITE, 16'hFFFF, 1'b0);
    send_item(spim_pkg::OP_WRITE, 16'h0000, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'hA5C3, 1'b0);
    send_item(spim_pkg::OP_WRITE, 16'h5A3C, 1'b1);
    repeat (5) send_item(spim_pkg::OP_WRITE, 16'($urandom), 1'($urandom));

    // shortest frames: eight words fill the receive FIFO, a ninth overruns
    reconfigure(4, 1'b0, 1'b0, 0, 2, 1'b1);
    tick_run(8 * 9 + 2);
    send_item(spim_pkg::OP_WRITE, 16'hFFFF, 1'b1);
    tick_run(11);
    repeat (9) send_item(spim_pkg::OP_READ, 16'($urandom), 1'($urandom));

    // disable part-way through a frame
    send_item(spim_pkg::OP_WRITE, 16'h00F5, 1'b0);
    tick_run(5);

    // slowest clock, frame size above range, mode 3: partial frame only
    reconfigure(31, 1'b1, 1'b1, 255, 254, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'hFFFF, 1'b1);
    tick_run(40);

    // frame size and prescale below range, mode 2
    reconfigure(0, 1'b1, 1'b0, 0, 1, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'hFFFF, 1'b0);
    send_item(spim_pkg::OP_WRITE, 16'h0000, 1'b1);
    tick_run(20);

    // odd prescale, mode 1, full 16-bit frame
    reconfigure(16, 1'b0, 1'b1, 0, 3, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'h8001, 1'b1);
    tick_run(35);
    send_item(spim_pkg::OP_READ, 16'h0000, 1'b0);

    // zero prescale with top rate, large odd prescale: partial frames
    reconfigure(17, 1'b1, 1'b0, 255, 0, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'h7FFE, 1'b1);
    tick_run(30);
    reconfigure(12, 1'b0, 1'b1, 0, 255, 1'b1);
    send_item(spim_pkg::OP_WRITE, 16'h0FF0, 1'b0);
    tick_run(30);

    // random phases, mostly short bit times
    repeat (14) begin
      frame = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(4, 16);
      presc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 4);
      rate  = (presc <= 4 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      reconfigure(frame, 1'($urandom), 1'($urandom), rate, presc,
                  ($urandom_range(0, 9) != 0));
      random_phase(104);
    end

    // drain and finish
    settle_results();
    repeat (8) @(posedge clk);
    if (tracker.expected_q.size() != 0) tracker.report("results still outstanding at the end");
    if (tracker.errors == 0) begin
      $display("[spi_master_with_fifos] OK");
    end else begin
      $display("[spi_master_with_fifos] ERROR");
    end
    $finish;
  end

endmodule
